@@ rtl/core/pov_p2b_pkg.sv @@
// ----------------------------------------------------------------------------
// POV polar-to-bitmap package
// Shared constants, item types and the sector trig tables built at
// elaboration.
// ----------------------------------------------------------------------------
package pov_p2b_pkg;

	localparam int NUM_LEDS       = 32;
	localparam int NUM_SECTORS    = 120;
	localparam int TRIG_FRAC_BITS = 15;

	localparam int unsigned     TURN_UNITS    = 5760;
	localparam int unsigned     QUARTER_UNITS = 1440;
	localparam longint unsigned PI_Q30        = 64'd3373259422;
	localparam int unsigned     SECTOR_STEP   = TURN_UNITS / NUM_SECTORS;

	localparam int SECTOR_W     = 7;
	localparam int SECTOR_CODES = 2 ** SECTOR_W;
	localparam int LED_W        = 5;
	localparam int OFFS_W       = 9;
	localparam int BASE_W       = 8;
	localparam int PITCH_W      = 4;
	localparam int SIZE_W       = 13;
	localparam int OUT_W        = 12;
	localparam int BYTE_W       = 4;
	localparam int BIT_W        = 3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = SIZE_W;

	localparam logic [SIZE_W-1:0]  WIDTH_RST  = SIZE_W'(256);
	localparam logic [SIZE_W-1:0]  HEIGHT_RST = SIZE_W'(256);
	localparam logic [BASE_W-1:0]  BASE_RST   = BASE_W'(50);
	localparam logic [PITCH_W-1:0] PITCH_RST  = PITCH_W'(6);

	// radius range covers both the largest LED index and the arm length
	localparam int LED_TOP = (NUM_LEDS - 1 > 2 ** LED_W - 1) ? NUM_LEDS - 1 : 2 ** LED_W - 1;
	localparam int RAD_MAX = (2 ** BASE_W - 1) + (2 ** PITCH_W - 1) * LED_TOP;
	localparam int RAD_W   = $clog2(RAD_MAX + 1);
	localparam int SPAN_W  = RAD_W + 1;
	localparam int TRIG_W  = TRIG_FRAC_BITS + 1;
	localparam int PROD_W  = TRIG_W + RAD_W + 1;
	localparam int DISP_W  = PROD_W - TRIG_FRAC_BITS;
	localparam int COORD_W = RAD_W + 3;
	localparam int NUM_W   = SPAN_W + SIZE_W;
	localparam int Q_W     = SIZE_W;

	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = (Q_W + DIV_BITS - 1) / DIV_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BITMAP_WIDTH  = CFG_IDX_W'(0),
		REG_BITMAP_HEIGHT = CFG_IDX_W'(1),
		REG_RADIUS_BASE   = CFG_IDX_W'(2),
		REG_RADIUS_PITCH  = CFG_IDX_W'(3)
	} cfg_reg_t;

	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef trig_t trig_tab_t [SECTOR_CODES];

	typedef struct packed {
		logic [1:0]               pad;
		logic signed [OFFS_W-1:0] offset_y;
		logic signed [OFFS_W-1:0] offset_x;
		logic [LED_W-1:0]         led_index;
		logic [SECTOR_W-1:0]      sector;
	} in_item_t;

	typedef struct packed {
		logic               pad;
		logic [BIT_W-1:0]   bit_shift;
		logic [BYTE_W-1:0]  byte_index;
		logic [OUT_W-1:0]   bmp_y;
		logic [OUT_W-1:0]   bmp_x;
	} out_item_t;

	typedef struct packed {
		logic [NUM_W-1:0]  rem_x;
		logic [NUM_W-1:0]  rem_y;
		logic [Q_W-1:0]    q_x;
		logic [Q_W-1:0]    q_y;
		logic [SPAN_W-1:0] span;
		logic              in_range;
		logic [BYTE_W-1:0] byte_index;
		logic [BIT_W-1:0]  bit_shift;
	} div_item_t;

	// Q30 Taylor series for the first quadrant, rounded to Q1.F
	function automatic longint unsigned quarter_sine(input longint unsigned r);
		longint unsigned t;
		longint unsigned t2;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned one;
		longint unsigned v;
		t    = (r * PI_Q30) / 64'd2880;
		t2   = (t * t) >> 30;
		term = t;
		sum  = t;
		one  = 64'd1 << TRIG_FRAC_BITS;
		// terms t^3 .. t^13, divisors 2k*(2k+1), alternating sign
		term = ((term * t2) >> 30) / 64'd6;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * t2) >> 30) / 64'd20;
		sum  = sum + term;
		term = ((term * t2) >> 30) / 64'd42;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * t2) >> 30) / 64'd72;
		sum  = sum + term;
		term = ((term * t2) >> 30) / 64'd110;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * t2) >> 30) / 64'd156;
		sum  = sum + term;
		v = (sum + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
		if (v > one - 64'd1) begin
			v = one - 64'd1;
		end
		return v;
	endfunction

	function automatic longint fixed_sine(input int unsigned angle);
		int unsigned a;
		int unsigned q;
		int unsigned r;
		longint      v;
		a = angle % TURN_UNITS;
		q = a / QUARTER_UNITS;
		r = a % QUARTER_UNITS;
		if (q % 2 == 1) begin
			v = longint'(quarter_sine(longint'(QUARTER_UNITS - r)));
		end else begin
			v = longint'(quarter_sine(longint'(r)));
		end
		return (q >= 2) ? -v : v;
	endfunction

	// cosine table, or the negated sine table for the y axis
	function automatic trig_tab_t build_trig_tab(input bit cosine);
		trig_tab_t   tab;
		int unsigned angle;
		for (int s = 0; s < SECTOR_CODES; s++) begin
			angle = SECTOR_STEP * s + SECTOR_STEP / 2;
			if (cosine) begin
				tab[s] = TRIG_W'(fixed_sine(angle + QUARTER_UNITS));
			end else begin
				tab[s] = TRIG_W'(-fixed_sine(angle));
			end
		end
		return tab;
	endfunction

	localparam trig_tab_t COS_TAB  = build_trig_tab(1'b1);
	localparam trig_tab_t NSIN_TAB = build_trig_tab(1'b0);

endpackage

@@ rtl/core/pov_p2b_div_pipe.sv @@
// ----------------------------------------------------------------------------
// POV polar-to-bitmap scaling divider
// Restoring divider for both coordinates, DIV_BITS quotient bits per stage,
// with a per-stage valid and hold.
// ----------------------------------------------------------------------------
module pov_p2b_div_pipe import pov_p2b_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output div_item_t out_item
);

	logic      dv_s [DIV_STAGES];
	div_item_t dd_s [DIV_STAGES];
	logic      en   [DIV_STAGES+1];

	assign en[DIV_STAGES] = out_ready;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		div_item_t src;
		div_item_t nxt;
		logic      src_v;

		if (k == 0) begin : g_first
			assign src   = in_item;
			assign src_v = in_valid;
		end else begin : g_next
			assign src   = dd_s[k-1];
			assign src_v = dv_s[k-1];
		end

		assign en[k] = !dv_s[k] || en[k+1];

		always_comb begin
			logic [NUM_W-1:0] dvs;
			logic             ge_x;
			logic             ge_y;
			int               b;
			dvs  = '0;
			ge_x = 1'b0;
			ge_y = 1'b0;
			b    = 0;
			nxt  = src;
			for (int j = 0; j < DIV_BITS; j++) begin
				b = Q_W - 1 - k * DIV_BITS - j;
				if (b >= 0) begin
					dvs  = NUM_W'(src.span) << b;
					ge_x = nxt.rem_x >= dvs;
					ge_y = nxt.rem_y >= dvs;
					if (ge_x) begin
						nxt.rem_x = nxt.rem_x - dvs;
					end
					if (ge_y) begin
						nxt.rem_y = nxt.rem_y - dvs;
					end
					nxt.q_x = {nxt.q_x[Q_W-2:0], ge_x};
					nxt.q_y = {nxt.q_y[Q_W-2:0], ge_y};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k] <= 1'b0;
			end else if (en[k]) begin
				dv_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				dd_s[k] <= nxt;
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = dv_s[DIV_STAGES-1];
	assign out_item  = dd_s[DIV_STAGES-1];

endmodule

@@ rtl/core/pov_polar_to_bitmap_address_top.sv @@
// ----------------------------------------------------------------------------
// POV polar-to-bitmap address generator
// Maps a (sector, LED, pan offset) request to the bitmap pixel and the packed
// state bit position of that LED.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   s_axis  | in        | tvalid / tready        | sector, led, offsets
//   m_axis  | out       | tvalid / tready        | pixel, state bit; in_range
//   cfg     | in        | cfg_we (no back-press) | bitmap size, radius setup
//
// One item per cycle while the output is not stalled; stages s1 to s4, then the
// divider stages that scale each coordinate to bitmap size, then s5 output.
// Each stage holds while its successor is full and stalled; empty stages keep
// filling, so items are taken while a result waits at the output.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module pov_polar_to_bitmap_address_top import pov_p2b_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [31:0]           s_axis_tdata,   // sector, led_index, offset_x, offset_y, pad
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [31:0]           m_axis_tdata,   // bmp_x, bmp_y, byte_index, bit_shift, pad
	output logic                  m_axis_tuser    // in_range
);

	logic [SIZE_W-1:0]  width_q;
	logic [SIZE_W-1:0]  height_q;
	logic [BASE_W-1:0]  base_q;
	logic [PITCH_W-1:0] pitch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			base_q   <= BASE_RST;
			pitch_q  <= PITCH_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BITMAP_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
				REG_BITMAP_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				REG_RADIUS_BASE:   base_q   <= cfg_data[BASE_W-1:0];
				REG_RADIUS_PITCH:  pitch_q  <= cfg_data[PITCH_W-1:0];
			endcase
		end
	end

	// stage enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic div_in_ready;
	logic div_out_valid;

	assign en_s5 = !v_s5 || m_axis_tready;
	assign en_s4 = !v_s4 || div_in_ready;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= div_out_valid;
			end
		end
	end

	// s1: table lookup, radius
	in_item_t          in_d;
	logic [RAD_W-1:0]  rad_d;
	logic [RAD_W-1:0]  rmax_d;

	assign in_d   = in_item_t'(s_axis_tdata);
	assign rad_d  = RAD_W'(base_q) + RAD_W'(pitch_q) * RAD_W'(in_d.led_index);
	assign rmax_d = RAD_W'(base_q) + RAD_W'(pitch_q) * RAD_W'(NUM_LEDS - 1);

	trig_t                    cos_s1;
	trig_t                    nsin_s1;
	logic [RAD_W-1:0]         rad_s1;
	logic [RAD_W-1:0]         rmax_s1;
	logic signed [OFFS_W-1:0] offx_s1;
	logic signed [OFFS_W-1:0] offy_s1;
	logic [BYTE_W-1:0]        byte_s1;
	logic [BIT_W-1:0]         bit_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			cos_s1  <= COS_TAB[in_d.sector];
			nsin_s1 <= NSIN_TAB[in_d.sector];
			rad_s1  <= rad_d;
			rmax_s1 <= rmax_d;
			offx_s1 <= in_d.offset_x;
			offy_s1 <= in_d.offset_y;
			byte_s1 <= in_d.sector[SECTOR_W-1:BIT_W];
			bit_s1  <= ~in_d.sector[BIT_W-1:0];
		end
	end

	// s2: trig times radius
	logic signed [PROD_W-1:0] cx_d, sy_d, r_d;

	assign r_d  = PROD_W'(signed'({1'b0, rad_s1}));
	assign cx_d = PROD_W'(cos_s1);
	assign sy_d = PROD_W'(nsin_s1);

	logic signed [PROD_W-1:0] px_s2;
	logic signed [PROD_W-1:0] py_s2;
	logic [RAD_W-1:0]         rmax_s2;
	logic [SPAN_W-1:0]        span_s2;
	logic signed [OFFS_W-1:0] offx_s2;
	logic signed [OFFS_W-1:0] offy_s2;
	logic [BYTE_W-1:0]        byte_s2;
	logic [BIT_W-1:0]         bit_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			px_s2   <= cx_d * r_d;
			py_s2   <= sy_d * r_d;
			rmax_s2 <= rmax_s1;
			span_s2 <= {rmax_s1, 1'b0};
			offx_s2 <= offx_s1;
			offy_s2 <= offy_s1;
			byte_s2 <= byte_s1;
			bit_s2  <= bit_s1;
		end
	end

	// s3: floor, shift into window, range check
	logic signed [DISP_W-1:0]  dx_d, dy_d;
	logic signed [COORD_W-1:0] xin_d, yin_d, rm_d, sp_d;
	logic                      inr_d;

	assign dx_d  = DISP_W'(px_s2 >>> TRIG_FRAC_BITS);
	assign dy_d  = DISP_W'(py_s2 >>> TRIG_FRAC_BITS);
	assign rm_d  = COORD_W'(signed'({1'b0, rmax_s2}));
	assign sp_d  = COORD_W'(signed'({1'b0, span_s2}));
	assign xin_d = COORD_W'(dx_d) + rm_d + COORD_W'(offx_s2);
	assign yin_d = COORD_W'(dy_d) + rm_d + COORD_W'(offy_s2);
	assign inr_d = (xin_d > 0) && (xin_d <= sp_d) && (yin_d > 0) && (yin_d <= sp_d);

	logic [SPAN_W-1:0] xc_s3;
	logic [SPAN_W-1:0] yc_s3;
	logic              inr_s3;
	logic [SPAN_W-1:0] span_s3;
	logic [BYTE_W-1:0] byte_s3;
	logic [BIT_W-1:0]  bit_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			xc_s3   <= xin_d[SPAN_W-1:0];
			yc_s3   <= yin_d[SPAN_W-1:0];
			inr_s3  <= inr_d;
			span_s3 <= span_s2;
			byte_s3 <= byte_s2;
			bit_s3  <= bit_s2;
		end
	end

	// s4: coordinate times (size - 1)
	logic [SIZE_W-1:0] wm1_d, hm1_d;
	div_item_t         div_d;

	assign wm1_d = (width_q == '0) ? '0 : width_q - SIZE_W'(1);
	assign hm1_d = (height_q == '0) ? '0 : height_q - SIZE_W'(1);

	always_comb begin
		div_d            = '0;
		div_d.rem_x      = NUM_W'(xc_s3) * NUM_W'(wm1_d);
		div_d.rem_y      = NUM_W'(yc_s3) * NUM_W'(hm1_d);
		div_d.span       = span_s3;
		div_d.in_range   = inr_s3;
		div_d.byte_index = byte_s3;
		div_d.bit_shift  = bit_s3;
	end

	div_item_t div_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			div_s4 <= div_d;
		end
	end

	div_item_t div_out;

	pov_p2b_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (div_in_ready),
		.in_item   (div_s4),
		.out_valid (div_out_valid),
		.out_ready (en_s5),
		.out_item  (div_out)
	);

	// s5: saturate, blank out of range, output register
	out_item_t res_d;

	always_comb begin
		res_d            = '0;
		res_d.byte_index = div_out.byte_index;
		res_d.bit_shift  = div_out.bit_shift;
		if (div_out.in_range) begin
			res_d.bmp_x = (|div_out.q_x[Q_W-1:OUT_W]) ? '1 : div_out.q_x[OUT_W-1:0];
			res_d.bmp_y = (|div_out.q_y[Q_W-1:OUT_W]) ? '1 : div_out.q_y[OUT_W-1:0];
		end
	end

	out_item_t res_s5;
	logic      inr_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			res_s5 <= res_d;
			inr_s5 <= div_out.in_range;
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = res_s5;
	assign m_axis_tuser  = inr_s5;

endmodule
